// ===== hw/rtl/pgmd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the PGM occupancy decoder.
// Used by pgmd_parser, pgmd_result_fifo and pgm_occupancy_decoder.
package pgmd_pkg;

	// Grid size limits checked against the header.
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int ACC_W    = 16;  // decimal token accumulator, saturating
	localparam int CELL_W   = 12;  // column and row fields of a result
	localparam int ROW_CNT_W = 13; // image row counter, reaches the height
	localparam int GRAY_W   = 8;
	localparam int THR_W    = 16;
	localparam int MAXVAL_LIMIT = 255;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_OCC_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREE_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEGATE_MODE    = 2'd2;

	localparam logic [THR_W-1:0] OCC_THRESHOLD_RST  = 16'd42598;
	localparam logic [THR_W-1:0] FREE_THRESHOLD_RST = 16'd16384;

	// Characters the parser looks for.
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Result queue.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_MAGIC_P,
		PH_MAGIC_D,
		PH_WIDTH,
		PH_HEIGHT,
		PH_MAXVAL,
		PH_PIXELS
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_MAGIC,
		ST_BAD_HEADER,
		ST_BAD_DIMS,
		ST_BAD_MAXVAL,
		ST_COUNT_MISMATCH
	} status_t;

	typedef enum logic [1:0] {
		CLS_FREE,
		CLS_OCCUPIED,
		CLS_UNKNOWN
	} cls_t;

	typedef enum logic {
		KIND_PIXEL,
		KIND_STATUS
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		cls_t              cls;
		logic [CELL_W-1:0] col;
		logic [CELL_W-1:0] row;
		status_t           status;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [THR_W-1:0] occ_thr;
		logic [THR_W-1:0] free_thr;
		logic             negate;
	} cfg_t;

endpackage

// ===== hw/rtl/pgm_occupancy_decoder.sv =====
`timescale 1ns / 1ps
// PGM occupancy decoder: takes one file byte per transfer (end_of_file on the
// last byte), parses a P2 or P5 header and classifies each pixel as free,
// occupied or unknown against the Q0.16 thresholds, sending column and flipped
// row with it; the last byte yields a status result, and the pixel results of a
// file are valid only if that status is ok. One byte is taken every cycle while
// the input does not stall: a byte waits in the input register while the parser
// updates its state, and its results are written into the output queue as the
// parser takes the byte, so the first result of a byte is offered from the queue's
// registers. A last byte that also yields a pixel gives two results, which drain
// over two output transfers; input stalls only when a byte waits in the input
// register and the four-entry output queue holds more than two results.
// Depends on pgmd_pkg, pgmd_parser and pgmd_result_fifo.
module pgm_occupancy_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [pgmd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pgmd_pkg::THR_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        file_byte,
	input  logic                              end_of_file,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              result_kind,
	output logic [1:0]                        cell_class,
	output logic [pgmd_pkg::CELL_W-1:0]       cell_column,
	output logic [pgmd_pkg::CELL_W-1:0]       cell_row,
	output logic [2:0]                        status_code,
	output logic                              last_of_file
);

	pgmd_pkg::cfg_t    cfg_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eof_s1;
	logic              room2, fire, accept;
	logic              pix_valid, st_valid;
	pgmd_pkg::result_t pix, st, out_data;

	assign fire     = valid_s1 && room2;
	assign in_stall = valid_s1 && !room2;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.occ_thr <= pgmd_pkg::OCC_THRESHOLD_RST;
			cfg_q.free_thr <= pgmd_pkg::FREE_THRESHOLD_RST;
			cfg_q.negate <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				pgmd_pkg::REG_OCC_THRESHOLD:  cfg_q.occ_thr <= cfg_data;
				pgmd_pkg::REG_FREE_THRESHOLD: cfg_q.free_thr <= cfg_data;
				pgmd_pkg::REG_NEGATE_MODE:    cfg_q.negate <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= file_byte;
			eof_s1 <= end_of_file;
		end
	end

	pgmd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (fire),
		.item_byte  (byte_s1),
		.item_eof   (eof_s1),
		.cfg        (cfg_q),
		.pix_valid  (pix_valid),
		.pix        (pix),
		.st_valid   (st_valid),
		.st         (st)
	);

	pgmd_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_a_valid (pix_valid),
		.push_a       (pix),
		.push_b_valid (st_valid),
		.push_b       (st),
		.room2        (room2),
		.out_valid    (out_valid),
		.out_data     (out_data),
		.out_stall    (out_stall)
	);

	assign result_kind  = out_data.kind;
	assign cell_class   = out_data.cls;
	assign cell_column  = out_data.col;
	assign cell_row     = out_data.row;
	assign status_code  = out_data.status;
	assign last_of_file = out_data.last;

endmodule

// ===== hw/rtl/pgmd_parser.sv =====
`timescale 1ns / 1ps
// PGM byte parser: header state, pixel counters and the occupancy compare.
// Produces up to two results per byte; depends on pgmd_pkg.
module pgmd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic [7:0]           item_byte,
	input  logic                 item_eof,
	input  pgmd_pkg::cfg_t       cfg,
	output logic                 pix_valid,
	output pgmd_pkg::result_t    pix,
	output logic                 st_valid,
	output pgmd_pkg::result_t    st
);

	pgmd_pkg::phase_t                 phase_q, n_phase;
	pgmd_pkg::status_t                err_q, n_err, st_code;
	logic                             ascii_q, n_ascii;
	logic [pgmd_pkg::ACC_W-1:0]       acc_q, n_acc, acc_new, emit_val;
	logic                             digit_q, n_digit;
	logic                             comment_q, n_comment;
	logic [pgmd_pkg::ACC_W-1:0]       width_q, n_width, height_q, n_height;
	logic [pgmd_pkg::GRAY_W-1:0]      maxg_q, n_maxg;
	logic [pgmd_pkg::CELL_W-1:0]      col_q, n_col;
	logic [pgmd_pkg::ROW_CNT_W-1:0]   row_q, n_row;
	logic                             complete_q, n_complete;
	logic                             emit, fin_complete, hdr_done;
	logic                             is_dig, is_sp, is_hash, is_nl;
	logic                             dims_bad;
	logic [pgmd_pkg::CELL_W:0]        col_inc;
	logic [pgmd_pkg::ROW_CNT_W-1:0]   row_inc;
	logic                             wrap, emit_done;

	function automatic logic [pgmd_pkg::ACC_W-1:0] acc_step(
		input logic [pgmd_pkg::ACC_W-1:0] acc,
		input logic [7:0]                 c
	);
		logic [19:0] sum;
		sum = 20'({acc, 3'b000}) + 20'({acc, 1'b0}) + 20'(c[3:0]);
		acc_step = (sum > 20'hFFFF) ? {pgmd_pkg::ACC_W{1'b1}} : sum[pgmd_pkg::ACC_W-1:0];
	endfunction

	function automatic logic val_bad(input logic [pgmd_pkg::ACC_W-1:0] v);
		val_bad = (v == '0) || (v > pgmd_pkg::ACC_W'(pgmd_pkg::MAXVAL_LIMIT));
	endfunction

	// Exact compare: occ * 65536 against threshold * maxval, with occ signed.
	function automatic pgmd_pkg::cls_t classify(
		input logic [pgmd_pkg::ACC_W-1:0]  v,
		input logic [pgmd_pkg::GRAY_W-1:0] m,
		input pgmd_pkg::cfg_t              c
	);
		logic signed [17:0] occ;
		logic signed [33:0] lhs, occ_lim, free_lim;
		logic [23:0]        p_occ, p_free;
		occ = c.negate ? $signed({2'b00, v})
			: ($signed({10'b0, m}) - $signed({2'b00, v}));
		lhs = {occ, 16'b0};
		p_occ = 24'(c.occ_thr) * 24'(m);
		p_free = 24'(c.free_thr) * 24'(m);
		occ_lim = $signed({10'b0, p_occ});
		free_lim = $signed({10'b0, p_free});
		if (lhs > occ_lim) begin
			classify = pgmd_pkg::CLS_OCCUPIED;
		end else if (lhs < free_lim) begin
			classify = pgmd_pkg::CLS_FREE;
		end else begin
			classify = pgmd_pkg::CLS_UNKNOWN;
		end
	endfunction

	assign is_dig  = (item_byte >= pgmd_pkg::CH_ZERO) && (item_byte <= pgmd_pkg::CH_NINE);
	assign is_sp   = (item_byte == pgmd_pkg::CH_SPACE) ||
		((item_byte >= pgmd_pkg::CH_TAB) && (item_byte <= pgmd_pkg::CH_CR));
	assign is_hash = (item_byte == pgmd_pkg::CH_HASH);
	assign is_nl   = (item_byte == pgmd_pkg::CH_NL);
	assign acc_new = acc_step(acc_q, item_byte);

	assign dims_bad = (width_q == '0) || (height_q == '0) ||
		(width_q > pgmd_pkg::ACC_W'(pgmd_pkg::MAX_WIDTH)) ||
		(height_q > pgmd_pkg::ACC_W'(pgmd_pkg::MAX_HEIGHT));

	// Counter advance for a pixel sent at the current position.
	assign col_inc   = {1'b0, col_q} + 1'b1;
	assign row_inc   = row_q + 1'b1;
	assign wrap      = (pgmd_pkg::ACC_W'(col_inc) >= width_q);
	assign emit_done = wrap && (pgmd_pkg::ACC_W'(row_inc) >= height_q);

	always_comb begin
		n_phase = phase_q;
		n_err = err_q;
		n_ascii = ascii_q;
		n_acc = acc_q;
		n_digit = digit_q;
		n_comment = comment_q;
		n_width = width_q;
		n_height = height_q;
		n_maxg = maxg_q;
		n_col = col_q;
		n_row = row_q;
		n_complete = complete_q;
		emit = 1'b0;
		emit_val = acc_q;
		hdr_done = 1'b0;
		fin_complete = 1'b0;
		st_valid = 1'b0;
		st_code = pgmd_pkg::ST_OK;
		if (item_valid && (err_q == pgmd_pkg::ST_OK)) begin
			case (phase_q)
				pgmd_pkg::PH_MAGIC_P: begin
					if (item_byte == pgmd_pkg::CH_P) begin
						n_phase = pgmd_pkg::PH_MAGIC_D;
					end else begin
						n_err = pgmd_pkg::ST_BAD_MAGIC;
					end
				end
				pgmd_pkg::PH_MAGIC_D: begin
					if (item_byte == pgmd_pkg::CH_TWO || item_byte == pgmd_pkg::CH_FIVE) begin
						n_ascii = (item_byte == pgmd_pkg::CH_TWO);
						n_phase = pgmd_pkg::PH_WIDTH;
					end else begin
						n_err = pgmd_pkg::ST_BAD_MAGIC;
					end
				end
				pgmd_pkg::PH_PIXELS: begin
					if (!complete_q) begin
						if (!ascii_q) begin
							emit = 1'b1;
							emit_val = pgmd_pkg::ACC_W'(item_byte);
						end else if (comment_q) begin
							if (is_nl) begin
								n_comment = 1'b0;
							end
						end else if (is_dig) begin
							n_acc = acc_new;
							n_digit = 1'b1;
						end else begin
							if (digit_q) begin
								n_acc = '0;
								n_digit = 1'b0;
								emit = 1'b1;
							end
							// The byte that ends the last pixel token is not looked at.
							if (!(digit_q && emit_done)) begin
								if (is_hash) begin
									n_comment = 1'b1;
								end else if (!is_sp) begin
									n_err = pgmd_pkg::ST_COUNT_MISMATCH;
								end
							end
						end
					end
				end
				default: begin
					if (comment_q) begin
						if (is_nl) begin
							n_comment = 1'b0;
						end
					end else if (is_dig) begin
						n_acc = acc_new;
						n_digit = 1'b1;
					end else begin
						if (digit_q) begin
							n_acc = '0;
							n_digit = 1'b0;
							if (phase_q == pgmd_pkg::PH_WIDTH) begin
								n_width = acc_q;
								n_phase = pgmd_pkg::PH_HEIGHT;
							end else if (phase_q == pgmd_pkg::PH_HEIGHT) begin
								n_height = acc_q;
								n_phase = pgmd_pkg::PH_MAXVAL;
							end else if (dims_bad) begin
								n_err = pgmd_pkg::ST_BAD_DIMS;
							end else if (val_bad(acc_q)) begin
								n_err = pgmd_pkg::ST_BAD_MAXVAL;
							end else begin
								n_maxg = acc_q[pgmd_pkg::GRAY_W-1:0];
								n_phase = pgmd_pkg::PH_PIXELS;
								// A raw file consumes this byte as the separator.
								hdr_done = 1'b1;
								if (ascii_q) begin
									if (is_hash) begin
										n_comment = 1'b1;
									end else if (!is_sp) begin
										n_err = pgmd_pkg::ST_COUNT_MISMATCH;
									end
								end
							end
						end
						if (!hdr_done && (n_err == pgmd_pkg::ST_OK)) begin
							if (is_hash) begin
								n_comment = 1'b1;
							end else if (!is_sp) begin
								n_err = pgmd_pkg::ST_BAD_HEADER;
							end
						end
					end
				end
			endcase
			if (emit) begin
				n_col = wrap ? '0 : col_inc[pgmd_pkg::CELL_W-1:0];
				n_row = wrap ? row_inc : row_q;
				n_complete = emit_done;
			end
		end
		if (item_valid && item_eof) begin
			st_valid = 1'b1;
			if (n_err != pgmd_pkg::ST_OK) begin
				st_code = n_err;
			end else if (n_phase == pgmd_pkg::PH_MAGIC_P || n_phase == pgmd_pkg::PH_MAGIC_D) begin
				st_code = pgmd_pkg::ST_BAD_MAGIC;
			end else if (n_phase != pgmd_pkg::PH_PIXELS) begin
				if (!n_digit || n_phase != pgmd_pkg::PH_MAXVAL) begin
					st_code = pgmd_pkg::ST_BAD_HEADER;
				end else if (dims_bad) begin
					st_code = pgmd_pkg::ST_BAD_DIMS;
				end else if (val_bad(n_acc)) begin
					st_code = pgmd_pkg::ST_BAD_MAXVAL;
				end else begin
					st_code = pgmd_pkg::ST_COUNT_MISMATCH;
				end
			end else begin
				fin_complete = n_complete;
				// A pixel token cut off by the end of the file still counts.
				if (ascii_q && n_digit && !n_complete) begin
					emit = 1'b1;
					emit_val = n_acc;
					fin_complete = emit_done;
				end
				st_code = fin_complete ? pgmd_pkg::ST_OK : pgmd_pkg::ST_COUNT_MISMATCH;
			end
			n_phase = pgmd_pkg::PH_MAGIC_P;
			n_err = pgmd_pkg::ST_OK;
			n_ascii = 1'b0;
			n_acc = '0;
			n_digit = 1'b0;
			n_comment = 1'b0;
			n_width = '0;
			n_height = '0;
			n_maxg = '0;
			n_col = '0;
			n_row = '0;
			n_complete = 1'b0;
		end
	end

	assign pix_valid  = emit;
	assign pix.kind   = pgmd_pkg::KIND_PIXEL;
	assign pix.cls    = classify(emit_val, maxg_q, cfg);
	assign pix.col    = col_q;
	assign pix.row    = height_q[pgmd_pkg::CELL_W-1:0] - 1'b1 - row_q[pgmd_pkg::CELL_W-1:0];
	assign pix.status = pgmd_pkg::ST_OK;
	assign pix.last   = 1'b0;

	assign st.kind   = pgmd_pkg::KIND_STATUS;
	assign st.cls    = pgmd_pkg::CLS_FREE;
	assign st.col    = '0;
	assign st.row    = '0;
	assign st.status = st_code;
	assign st.last   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pgmd_pkg::PH_MAGIC_P;
			err_q <= pgmd_pkg::ST_OK;
			ascii_q <= 1'b0;
			acc_q <= '0;
			digit_q <= 1'b0;
			comment_q <= 1'b0;
			width_q <= '0;
			height_q <= '0;
			maxg_q <= '0;
			col_q <= '0;
			row_q <= '0;
			complete_q <= 1'b0;
		end else begin
			phase_q <= n_phase;
			err_q <= n_err;
			ascii_q <= n_ascii;
			acc_q <= n_acc;
			digit_q <= n_digit;
			comment_q <= n_comment;
			width_q <= n_width;
			height_q <= n_height;
			maxg_q <= n_maxg;
			col_q <= n_col;
			row_q <= n_row;
			complete_q <= n_complete;
		end
	end

	// The last byte of a file always returns the parser to a clean start.
	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_eof |=> phase_q == pgmd_pkg::PH_MAGIC_P &&
			err_q == pgmd_pkg::ST_OK && !complete_q)
		else $error("parser state not cleared after end of file");

	// The first error of a file is kept until the file ends.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != pgmd_pkg::ST_OK) && !(item_valid && item_eof) |=> err_q == $past(err_q))
		else $error("error code changed inside a file");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == pgmd_pkg::PH_PIXELS && !complete_q |->
			{{(pgmd_pkg::ACC_W-pgmd_pkg::CELL_W){1'b0}}, col_q} < width_q)
		else $error("column counter beyond image width");

	a_complete_phase: assert property (@(posedge clk) disable iff (!arst_n)
		complete_q |-> phase_q == pgmd_pkg::PH_PIXELS)
		else $error("pixels complete outside the pixel phase");

endmodule

// ===== hw/rtl/pgmd_result_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle while room2 shows room for two,
// hands out one per transfer. Depends on pgmd_pkg for the result type and depth.
module pgmd_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_a_valid,
	input  pgmd_pkg::result_t push_a,
	input  logic              push_b_valid,
	input  pgmd_pkg::result_t push_b,
	output logic              room2,
	output logic              out_valid,
	output pgmd_pkg::result_t out_data,
	input  logic              out_stall
);

	pgmd_pkg::result_t                mem_q [pgmd_pkg::FIFO_DEPTH];
	logic [pgmd_pkg::FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q, wr_ptr_b;
	logic [pgmd_pkg::FIFO_CW-1:0]     count_q;
	logic [1:0]                       npush;
	logic                             pop;
	pgmd_pkg::result_t                first;

	assign npush     = {1'b0, push_a_valid} + {1'b0, push_b_valid};
	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign room2     = (count_q <= pgmd_pkg::FIFO_CW'(pgmd_pkg::FIFO_DEPTH - 2));
	assign first     = push_a_valid ? push_a : push_b;
	assign wr_ptr_b  = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (npush != 2'd0) begin
			mem_q[wr_ptr_q] <= first;
		end
		if (npush == 2'd2) begin
			mem_q[wr_ptr_b] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + pgmd_pkg::FIFO_AW'(npush);
			rd_ptr_q <= rd_ptr_q + pgmd_pkg::FIFO_AW'(pop);
			count_q <= count_q + pgmd_pkg::FIFO_CW'(npush) - pgmd_pkg::FIFO_CW'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pgmd_pkg::FIFO_CW'(pgmd_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_a_valid || push_b_valid) |-> room2)
		else $error("results pushed without room for two");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (npush == 2'd0) && (count_q == pgmd_pkg::FIFO_CW'(1)) |=> !out_valid)
		else $error("result queue not empty after last transfer");

endmodule
